/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the jitter block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define H23J_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define H23J_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/h23j_pkg.sv */
// ----------------------------------------------------------------------------
// h23j_pkg
// Types, widths and constant tables for the base 2/3 Halton jitter block.
// ----------------------------------------------------------------------------
`default_nettype none

package h23j_pkg;

   // Phase count default; hardware widths cover phase counts up to 4096
   localparam int PHASES_DEF = 128;

   // Index 1..4096 and raw remainders below 8192
   localparam int IDX_W = 13;

   // Result width and scale (units of 2^-16)
   localparam int Q_W  = 16;
   localparam int Q_SH = Q_W + 1;

   // Base 3 digits are handled in two groups of four trits
   localparam int TRIT_GRP = 4;
   localparam int GRP_SPAN = 81;
   localparam int GRP_W    = 7;
   localparam int HI_W     = 6;

   // idx / 81 by reciprocal: exact for idx below 2^13
   localparam int             DIV81_SH  = 20;
   localparam int             DIV81_W   = 14;
   localparam logic [DIV81_W-1:0] DIV81_MUL =
      DIV81_W'(((1 << DIV81_SH) + GRP_SPAN - 1) / GRP_SPAN);

   // Mirrored base 3 value over eight trits, denominator 3^8
   localparam int N3_W = 13;
   localparam int DEN3 = 6561;

   // Rounded q = floor((n*2^17 + 6561) / 13122), numerator below 2^30
   localparam int                T3_W     = 30;
   localparam int                DIV3_SH  = 44;
   localparam int                DIV3_W   = 31;
   localparam logic [DIV3_W-1:0] DIV3_MUL =
      DIV3_W'(((64'd1 << DIV3_SH) + 2 * DEN3 - 1) / (2 * DEN3));

   // Four-trit mirror table
   typedef logic [GRP_W-1:0] grp_type;
   typedef grp_type rev3_tbl_type [GRP_SPAN];

   function automatic rev3_tbl_type build_rev3();
      rev3_tbl_type tbl;
      int           x;
      int           r;
      for (int v = 0; v < GRP_SPAN; v++) begin
         x = v;
         r = 0;
         for (int k = 0; k < TRIT_GRP; k++) begin
            r = r * 3 + x % 3;
            x = x / 3;
         end
         tbl[v] = GRP_W'(r);
      end
      return tbl;
   endfunction

   localparam rev3_tbl_type REV3_TBL = build_rev3();

   // Index transfer between the modulo front end and the mirror back end
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } idx_xfer_type;

endpackage

`default_nettype wire

/* rtl/h23j_mod.sv */
// ----------------------------------------------------------------------------
// h23j_mod
// Three-stage front end: forms idx = (frame mod PHASES) + 1 by reciprocal
// multiply, product subtract and one conditional correction.
// ----------------------------------------------------------------------------
`default_nettype none

module h23j_mod
   import h23j_pkg::*;
#(
   parameter int PHASES = PHASES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [31:0]  in_frame,
   output logic              in_stall,
   output idx_xfer_type      out_xfer,
   input  wire logic         out_stall
);

   localparam logic [31:0]      RECIP_P = 32'((64'd1 << 32) / PHASES);
   localparam logic [IDX_W-1:0] PHASE_N = IDX_W'(PHASES);

   logic                   s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]       s1_frame_ff, s1_frame_in;
   logic [IDX_W-1:0]       s1_qest_ff, s1_qest_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]       s2_rraw_ff, s2_rraw_in;
   logic                   s3_valid_ff, s3_valid_in;
   logic [IDX_W-1:0]       s3_idx_ff, s3_idx_in;

   logic                   s1_free, s2_free, s3_free;
   logic [63:0]            qest_prod;
   logic [2*IDX_W-1:0]     qp_prod;
   logic [IDX_W-1:0]       rem;

   // Each stage takes a transfer when empty or when it drains this cycle
   assign s3_free  = !s3_valid_ff || !out_stall;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_stall = !s1_free;

   // Stage 1: quotient estimate, low or exact by at most one
   always_comb begin
      qest_prod   = in_frame * RECIP_P;
      s1_valid_in = s1_free ? in_valid : s1_valid_ff;
      s1_frame_in = s1_free ? in_frame[IDX_W-1:0] : s1_frame_ff;
      s1_qest_in  = s1_free ? qest_prod[32 +: IDX_W] : s1_qest_ff;
   end

   // Stage 2: raw remainder below twice the phase count, low bits suffice
   always_comb begin
      qp_prod     = s1_qest_ff * PHASE_N;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      s2_rraw_in  = s2_free ? (s1_frame_ff - qp_prod[IDX_W-1:0]) : s2_rraw_ff;
   end

   // Stage 3: correct once and step to a one-based index
   always_comb begin
      rem         = (s2_rraw_ff >= PHASE_N) ? (s2_rraw_ff - PHASE_N) : s2_rraw_ff;
      s3_valid_in = s3_free ? s2_valid_ff : s3_valid_ff;
      s3_idx_in   = s3_free ? (rem + IDX_W'(1)) : s3_idx_ff;
   end

   // Clear valid bits on reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_frame_ff <= s1_frame_in;
      s1_qest_ff  <= s1_qest_in;
      s2_rraw_ff  <= s2_rraw_in;
      s3_idx_ff   <= s3_idx_in;
   end

   assign out_xfer.valid = s3_valid_ff;
   assign out_xfer.idx   = s3_idx_ff;

endmodule

`default_nettype wire

/* rtl/h23j_rinv.sv */
// ----------------------------------------------------------------------------
// h23j_rinv
// Four-stage back end: base 2 bit mirror and base 3 trit mirror of the
// index, scaled to units of 2^-16 with one half removed.
// ----------------------------------------------------------------------------
`default_nettype none

module h23j_rinv
   import h23j_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire idx_xfer_type        in_xfer,
   output logic                     in_stall,
   output logic                     out_valid,
   output logic signed [Q_W-1:0]    out_x,
   output logic signed [Q_W-1:0]    out_y,
   input  wire logic                out_stall
);

   logic                   s4_valid_ff, s4_valid_in;
   logic [Q_W-1:0]         s4_xq_ff, s4_xq_in;
   logic [HI_W-1:0]        s4_hi_ff, s4_hi_in;
   logic [IDX_W-1:0]       s4_idx_ff, s4_idx_in;
   logic                   s5_valid_ff, s5_valid_in;
   logic [Q_W-1:0]         s5_xq_ff, s5_xq_in;
   logic [GRP_W-1:0]       s5_lrev_ff, s5_lrev_in;
   logic [GRP_W-1:0]       s5_hrev_ff, s5_hrev_in;
   logic                   s6_valid_ff, s6_valid_in;
   logic [Q_W-1:0]         s6_xq_ff, s6_xq_in;
   logic [N3_W-1:0]        s6_n3_ff, s6_n3_in;
   logic                   s7_valid_ff, s7_valid_in;
   logic [Q_W-1:0]         s7_xq_ff, s7_xq_in;
   logic [Q_W-1:0]         s7_yq_ff, s7_yq_in;

   logic                   s4_free, s5_free, s6_free, s7_free;
   logic [IDX_W+DIV81_W-1:0] hi_prod;
   logic [IDX_W-1:0]       hi_span;
   logic [IDX_W-1:0]       lo_full;
   logic [T3_W-1:0]        t3;
   logic [T3_W+DIV3_W-1:0] y_prod;

   // Place bit j of the index at weight 2^-(j+1)
   function automatic logic [Q_W-1:0] bit_mirror(input logic [IDX_W-1:0] v);
      logic [Q_W-1:0] m;
      m = '0;
      for (int j = 0; j < IDX_W; j++) begin
         m[Q_W-1-j] = v[j];
      end
      return m;
   endfunction

   // Backward ready chain
   assign s7_free  = !s7_valid_ff || !out_stall;
   assign s6_free  = !s6_valid_ff || s7_free;
   assign s5_free  = !s5_valid_ff || s6_free;
   assign s4_free  = !s4_valid_ff || s5_free;
   assign in_stall = !s4_free;

   // Stage 4: base 2 mirror, upper trit group by reciprocal of 81
   always_comb begin
      hi_prod     = in_xfer.idx * DIV81_MUL;
      s4_valid_in = s4_free ? in_xfer.valid : s4_valid_ff;
      s4_xq_in    = s4_free ? bit_mirror(in_xfer.idx) : s4_xq_ff;
      s4_hi_in    = s4_free ? hi_prod[DIV81_SH +: HI_W] : s4_hi_ff;
      s4_idx_in   = s4_free ? in_xfer.idx : s4_idx_ff;
   end

   // Stage 5: lower trit group, mirror both groups through the table
   always_comb begin
      hi_span     = IDX_W'(s4_hi_ff) * IDX_W'(GRP_SPAN);
      lo_full     = s4_idx_ff - hi_span;
      s5_valid_in = s5_free ? s4_valid_ff : s5_valid_ff;
      s5_xq_in    = s5_free ? s4_xq_ff : s5_xq_ff;
      s5_lrev_in  = s5_free ? REV3_TBL[lo_full[GRP_W-1:0]] : s5_lrev_ff;
      s5_hrev_in  = s5_free ? REV3_TBL[GRP_W'(s4_hi_ff)] : s5_hrev_ff;
   end

   // Stage 6: join the groups into the mirrored numerator over 3^8
   always_comb begin
      s6_valid_in = s6_free ? s5_valid_ff : s6_valid_ff;
      s6_xq_in    = s6_free ? s5_xq_ff : s6_xq_ff;
      s6_n3_in    = s6_free ? (N3_W'(s5_lrev_ff) * N3_W'(GRP_SPAN) + N3_W'(s5_hrev_ff))
                            : s6_n3_ff;
   end

   // Stage 7: scale to 2^-16 with round to nearest by reciprocal of 2*3^8
   always_comb begin
      t3          = {s6_n3_ff, {Q_SH{1'b0}}} + T3_W'(DEN3);
      y_prod      = t3 * DIV3_MUL;
      s7_valid_in = s7_free ? s6_valid_ff : s7_valid_ff;
      s7_xq_in    = s7_free ? s6_xq_ff : s7_xq_ff;
      s7_yq_in    = s7_free ? y_prod[DIV3_SH +: Q_W] : s7_yq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
         s7_valid_ff <= s7_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_xq_ff   <= s4_xq_in;
      s4_hi_ff   <= s4_hi_in;
      s4_idx_ff  <= s4_idx_in;
      s5_xq_ff   <= s5_xq_in;
      s5_lrev_ff <= s5_lrev_in;
      s5_hrev_ff <= s5_hrev_in;
      s6_xq_ff   <= s6_xq_in;
      s6_n3_ff   <= s6_n3_in;
      s7_xq_ff   <= s7_xq_in;
      s7_yq_ff   <= s7_yq_in;
   end

   // Remove one half by flipping the top bit
   assign out_valid = s7_valid_ff;
   assign out_x     = signed'({~s7_xq_ff[Q_W-1], s7_xq_ff[Q_W-2:0]});
   assign out_y     = signed'({~s7_yq_ff[Q_W-1], s7_yq_ff[Q_W-2:0]});

endmodule

`default_nettype wire

/* rtl/halton_2_3_jitter_top.sv */
// ----------------------------------------------------------------------------
// halton_2_3_jitter_top
// Sub-pixel jitter from the Halton sequence in bases 2 and 3.
// ----------------------------------------------------------------------------
//   Channel | Ports                                  | Direction
//   --------+----------------------------------------+----------
//   req     | req_valid, req_stall, req_frame_number | in
//   rsp     | rsp_valid, rsp_stall, rsp_jitter_x/_y  | out
//
//   One transfer in per cycle while req_stall is low, one result out per
//   transfer: three stages form the phase index, four mirror it.
//   The deepest stages hold the 32x32 reciprocal multiply and the 30x31
//   rounding multiply for the base 3 value.
//   Synchronous reset clears the stage valid bits only; nothing else is kept.
//   A stall on rsp freezes only full stages, so bubbles close up and req is
//   stalled only when all seven stages hold results.
// ----------------------------------------------------------------------------
`default_nettype none

module halton_2_3_jitter_top
   import h23j_pkg::*;
#(
   parameter int PHASES = PHASES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [31:0]         req_frame_number,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [Q_W-1:0]    rsp_jitter_x,
   output logic signed [Q_W-1:0]    rsp_jitter_y
);

   idx_xfer_type idx_xfer;
   logic         idx_stall;

   // Phase index front end
   h23j_mod #(
      .PHASES (PHASES)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_frame  (req_frame_number),
      .in_stall  (req_stall),
      .out_xfer  (idx_xfer),
      .out_stall (idx_stall)
   );

   // Radical inverse back end
   h23j_rinv u_rinv (
      .clock     (clock),
      .reset     (reset),
      .in_xfer   (idx_xfer),
      .in_stall  (idx_stall),
      .out_valid (rsp_valid),
      .out_x     (rsp_jitter_x),
      .out_y     (rsp_jitter_y),
      .out_stall (rsp_stall)
   );

endmodule

`default_nettype wire

/* rtl/h23j_checker.sv */
// ----------------------------------------------------------------------------
// h23j_checker
// Port-level checks for the Halton jitter block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module h23j_checker
   import h23j_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [31:0]         req_frame_number,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic signed [Q_W-1:0] rsp_jitter_x,
   input  wire logic signed [Q_W-1:0] rsp_jitter_y
);

   // Hold a stalled request
   `H23J_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_frame_number), "stalled request changed")

   // Hold a stalled result
   `H23J_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_jitter_x) && $stable(rsp_jitter_y), "stalled result changed")

   // Input backs up only when every stage is full behind a stalled output
   `H23J_ASSERT_NOW(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with room in the pipe")

   // Index is at most 13 bits, so the base 2 mirror has clear low bits
   `H23J_ASSERT_NOW(a_x_grain, clock, reset, rsp_valid, rsp_jitter_x[2:0] == 3'b000, "base 2 jitter off grid")

   // Index is never zero, so neither value reaches minus one half
   `H23J_ASSERT_NOW(a_nonzero_idx, clock, reset, rsp_valid, (rsp_jitter_x != 16'sh8000) && (rsp_jitter_y != 16'sh8000), "jitter at minus one half")

endmodule

bind halton_2_3_jitter_top h23j_checker u_checker (.*);

`default_nettype wire

/* test/halton_2_3_jitter_top_tb.sv */
// ----------------------------------------------------------------------------
// halton_2_3_jitter_top_tb
// Drives frame numbers into the base 2/3 Halton jitter block and checks each
// jitter pair against an in-bench prediction of the digit-reversed index.
// A short directed set comes first, then about 1250 random frames with random
// gaps and output stalls, one long output hold-off and one full drain pause.
// ----------------------------------------------------------------------------

module halton_2_3_jitter_top_tb;
   import h23j_pkg::*;

   localparam int PHASES    = PHASES_DEF;
   localparam int N_RANDOM  = 1250;
   localparam int IDLE_PCT  = 33;
   localparam int HOLD_CYC  = 80;
   localparam int DRAIN_CYC = 20;

   typedef struct packed {
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
   } jitter_pair_type;

   // Expected jitter pairs in transfer order, plus mismatch bookkeeping
   class jitter_scoreboard;
      jitter_pair_type expected_jitter[$];
      int              errors          = 0;
      int              frames_noted    = 0;
      int              results_checked = 0;

      // Mirror the digits of idx about the radix point, scale to 2^-16, round
      static function logic [Q_W-1:0] halton_q16(int unsigned idx, int unsigned radix);
         longint unsigned num;
         longint unsigned den;
         longint unsigned rest;
         longint unsigned q;
         num  = 0;
         den  = 1;
         rest = idx;
         while (rest > 0) begin
            num  = num * radix + rest % radix;
            den  = den * radix;
            rest = rest / radix;
         end
         q = ((num << Q_SH) + den) / (2 * den);
         // hold at full scale before the half is taken off
         if (q > 65535) q = 65535;
         return Q_W'(q);
      endfunction

      function void note_frame(logic [31:0] frame);
         int unsigned     idx;
         logic [Q_W-1:0]  qx;
         logic [Q_W-1:0]  qy;
         jitter_pair_type pair;
         idx    = (frame % PHASES) + 1;
         qx     = halton_q16(idx, 2);
         qy     = halton_q16(idx, 3);
         // subtract one half: same as adding it modulo 2^16
         pair.x = qx + 16'h8000;
         pair.y = qy + 16'h8000;
         expected_jitter.push_back(pair);
         frames_noted++;
      endfunction

      task report_mismatch(string msg);
         if (errors < 20) $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_jitter(logic signed [Q_W-1:0] x, logic signed [Q_W-1:0] y);
         jitter_pair_type want;
         if (expected_jitter.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d", x, y));
         end else begin
            want = expected_jitter.pop_front();
            results_checked++;
            if (x !== want.x)
               report_mismatch($sformatf("jitter_x got %0d want %0d", x, want.x));
            if (y !== want.y)
               report_mismatch($sformatf("jitter_y got %0d want %0d", y, want.y));
         end
      endtask

      function int pending_count();
         return expected_jitter.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [31:0]           req_frame_number;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [Q_W-1:0] rsp_jitter_x;
   logic signed [Q_W-1:0] rsp_jitter_y;

   // Both sides run without idling while this is set
   logic                  calm;
   logic                  holdoff_request;

   jitter_scoreboard      sb = new();

   halton_2_3_jitter_top #(
      .PHASES (PHASES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_jitter_x     (rsp_jitter_x),
      .rsp_jitter_y     (rsp_jitter_y)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one frame, idling at random first; return once the transfer is taken
   task send_frame(logic [31:0] frame);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_frame_number <= frame;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_frame(frame);
   endtask

   // Park the input and wait until every expected result has come back
   task drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      bit holdoff_done;
      holdoff_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request && !holdoff_done) begin
            holdoff_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYC) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_jitter(rsp_jitter_x, rsp_jitter_y);
   end

   // Stimulus
   initial begin
      logic [31:0] directed_frames[$];
      logic [31:0] frame;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_frame_number <= '0;
      calm             <= 1'b0;
      holdoff_request  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Index extremes, digit-count boundaries in both bases, wrap of the phase
      // counter and all-ones / all-zeros / alternating frame numbers
      directed_frames = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'd8, 32'd25, 32'd26,
                          32'd63, 32'd64, 32'd79, 32'd80, 32'd126, 32'd127, 32'd128,
                          32'd129, 32'd255, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hFFFF_FF80, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                          32'hAAAA_AAAA, 32'h5555_5555};
      foreach (directed_frames[i]) send_frame(directed_frames[i]);
      drain_results();

      for (int i = 0; i < N_RANDOM; i++) begin
         // quiet stretch on both sides
         if (i == 500) calm <= 1'b1;
         if (i == 700) calm <= 1'b0;
         if (i == 300) holdoff_request <= 1'b1;
         if (i == 800) drain_results();
         case ($urandom_range(0, 3))
            0, 1:    frame = $urandom;
            2:       frame = $urandom_range(0, 3 * PHASES - 1);
            default: frame = ($urandom & ~(PHASES - 1)) | $urandom_range(PHASES - 4, PHASES - 1);
         endcase
         send_frame(frame);
      end

      // Drain, then let the pipeline settle
      drain_results();
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Covered %0d frame transfers and %0d checked results, with random gaps,",
               sb.frames_noted, sb.results_checked);
      $display("a full output hold-off and drain pauses; %0d mismatches.", sb.errors);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", sb.pending_count());
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/h23j_pkg.sv
rtl/h23j_mod.sv
rtl/h23j_rinv.sv
rtl/halton_2_3_jitter_top.sv
rtl/h23j_checker.sv
test/halton_2_3_jitter_top_tb.sv
